@@ design/waveform_bucket_reducer_assert.svh @@
// assertion macros shared by the checker
`ifndef WAVEFORM_BUCKET_REDUCER_ASSERT_SVH
`define WAVEFORM_BUCKET_REDUCER_ASSERT_SVH
// implication checked every clock outside reset
`define WBR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define WBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/wbr_pkg.sv @@
// ----------------------------------------------------------------------------
// wbr_pkg
// shared constants, types and helpers of the waveform bucket reducer
// ----------------------------------------------------------------------------
package wbr_pkg;
    localparam int BUCKETS     = 256;
    localparam int COUNT_BITS  = 24;
    localparam int BKT_BITS    = $clog2(BUCKETS);
    localparam int NUM_BITS    = COUNT_BITS + BKT_BITS + 1;
    localparam int WSUM_BITS   = COUNT_BITS + 17;
    localparam int ESUM_BITS   = WSUM_BITS + 15;
    localparam int CFG_BITS    = 24;
    localparam int Q_BITS      = 9;
    localparam logic [16:0] WEIGHT_FLOOR = 17'd33;
    localparam logic [15:0] ENERGY_ONE   = 16'd16384;

    localparam logic CFG_SAMPLE_COUNT  = 1'b0;
    localparam logic CFG_BANDS_ENABLED = 1'b1;

    typedef struct packed {
        logic [7:0]           bucket;
        logic [16:0]          peak;
        logic [ESUM_BITS-1:0] esum0;
        logic [ESUM_BITS-1:0] esum1;
        logic [ESUM_BITS-1:0] esum2;
        logic [WSUM_BITS-1:0] wsum;
        logic                 last;
    } t_bucket;

    typedef struct packed {
        logic [7:0] bucket_number;
        logic [7:0] peak_low_byte;
        logic [7:0] peak_high_byte;
        logic [7:0] bass_level;
        logic [7:0] mid_level;
        logic [7:0] treble_level;
        logic       final_bucket;
    } t_result;

    typedef struct packed {
        logic signed [15:0] mix_sample;
        logic signed [15:0] bass_energy;
        logic signed [15:0] mid_energy;
        logic signed [15:0] treble_energy;
    } t_item;

    function automatic logic [15:0] clamp_energy(input logic signed [15:0] e);
        logic [15:0] r;
        if (e < 0) r = '0;
        else if (e > $signed({1'b0, ENERGY_ONE[14:0]}) || e[14]) r = ENERGY_ONE;
        else r = e;
        if (!e[15] && e[14] && e[13:0] == '0) r = ENERGY_ONE;
        return r;
    endfunction
endpackage

@@ design/wbr_stream_if.sv @@
// ----------------------------------------------------------------------------
// wbr_stream_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface wbr_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/wbr_front.sv @@
// ----------------------------------------------------------------------------
// wbr_front
// per-sample accumulation and bucket boundary tracking
// ----------------------------------------------------------------------------
module wbr_front import wbr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_restart,
    input  logic [CFG_BITS-1:0]  i_count,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_item                i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_bucket              o_bucket
);
    logic [NUM_BITS-1:0] r_scaled, r_end, n_scaled, s1, cnt;
    logic [BKT_BITS-1:0] r_bkt;
    logic [16:0] r_peak0, r_peak1, a, w;
    logic [ESUM_BITS-1:0] r_es0 [3], r_es1 [3];
    logic [WSUM_BITS-1:0] r_ws0, r_ws1;
    logic [15:0] e [3];
    logic [31:0] ew [3];
    logic r_ov;
    t_bucket r_out;
    logic last, done, take, second;

    assign cnt = (i_count < CFG_BITS'(BUCKETS)) ? NUM_BITS'(BUCKETS) : NUM_BITS'(i_count);
    assign a = i_item.mix_sample[15] ? 17'(-{i_item.mix_sample[15], i_item.mix_sample})
                                     : 17'(i_item.mix_sample);
    assign w = (a < WEIGHT_FLOOR) ? WEIGHT_FLOOR : a;
    assign e[0] = clamp_energy(i_item.bass_energy);
    assign e[1] = clamp_energy(i_item.mid_energy);
    assign e[2] = clamp_energy(i_item.treble_energy);
    always_comb begin
        for (int k = 0; k < 3; k++) ew[k] = 32'(e[k]) * 32'(w);
    end
    assign s1 = r_scaled + NUM_BITS'(BUCKETS);
    assign n_scaled = s1;
    assign last = (r_bkt == BKT_BITS'(BUCKETS - 1));
    assign done = (r_end <= s1);
    assign second = !last && (r_end < s1);
    // output slot must be free or draining before any sample is taken
    assign o_ready = !r_ov || i_ready;
    assign take = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_bucket = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_restart) begin
            r_scaled <= '0;
            r_end <= cnt;
            r_bkt <= '0;
            r_peak0 <= '0; r_peak1 <= '0;
            r_ws0 <= '0; r_ws1 <= '0;
            for (int k = 0; k < 3; k++) begin r_es0[k] <= '0; r_es1[k] <= '0; end
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (take) begin
                logic [16:0] p0;
                logic [ESUM_BITS-1:0] s0 [3];
                logic [WSUM_BITS-1:0] w0;
                p0 = (a > r_peak0) ? a : r_peak0;
                for (int k = 0; k < 3; k++) s0[k] = r_es0[k] + ESUM_BITS'(ew[k]);
                w0 = r_ws0 + WSUM_BITS'(w);
                if (done) begin
                    r_ov <= 1'b1;
                    r_out.bucket <= 8'(r_bkt);
                    r_out.peak <= p0;
                    r_out.esum0 <= s0[0]; r_out.esum1 <= s0[1]; r_out.esum2 <= s0[2];
                    r_out.wsum <= w0;
                    r_out.last <= last;
                    if (last) begin
                        r_scaled <= '0; r_end <= cnt; r_bkt <= '0;
                        r_peak0 <= '0; r_peak1 <= '0; r_ws0 <= '0; r_ws1 <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_es0[k] <= '0; r_es1[k] <= '0;
                        end
                    end else begin
                        r_scaled <= n_scaled;
                        r_end <= r_end + cnt;
                        r_bkt <= r_bkt + BKT_BITS'(1);
                        r_peak0 <= second ? ((a > r_peak1) ? a : r_peak1) : r_peak1;
                        r_ws0 <= second ? r_ws1 + WSUM_BITS'(w) : r_ws1;
                        for (int k = 0; k < 3; k++) begin
                            r_es0[k] <= second ? r_es1[k] + ESUM_BITS'(ew[k]) : r_es1[k];
                            r_es1[k] <= '0;
                        end
                        r_peak1 <= '0; r_ws1 <= '0;
                    end
                end else begin
                    r_scaled <= n_scaled;
                    r_peak0 <= p0; r_ws0 <= w0;
                    for (int k = 0; k < 3; k++) r_es0[k] <= s0[k];
                end
            end
        end
    end
endmodule

@@ design/wbr_queue.sv @@
// ----------------------------------------------------------------------------
// wbr_queue
// two-entry queue between the accumulator front and the divider back
// ----------------------------------------------------------------------------
module wbr_queue import wbr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_bucket i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_bucket o_data
);
    t_bucket r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ design/wbr_back.sv @@
// ----------------------------------------------------------------------------
// wbr_back
// per-bucket peak quantization and band averages by a restoring divider
// ----------------------------------------------------------------------------
module wbr_back import wbr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_bands_enabled,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_bucket i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    localparam int NUM_W = ESUM_BITS + 9;
    localparam int DEN_W = WSUM_BITS + 15;

    t_state r_state;
    t_bucket r_b;
    logic [1:0] r_band;
    logic [3:0] r_bit;
    logic [NUM_W-1:0] r_rem;
    logic [Q_BITS-1:0] r_q;
    logic [7:0] r_lvl [3];
    logic [7:0] r_bkt_no, r_plo, r_phi;
    logic r_final;
    logic [DEN_W:0] den;
    logic [NUM_W-1:0] num;
    logic [ESUM_BITS-1:0] esel;
    logic [NUM_W:0] trial;
    logic [25:0] plo, phi;

    assign den = {1'b0, r_b.wsum, 15'd0};
    always_comb begin
        case (r_band)
            2'd0: esel = r_b.esum0;
            2'd1: esel = r_b.esum1;
            default: esel = r_b.esum2;
        endcase
    end
    // rounded quotient floor((510*s + d) / 2d), one bit per cycle
    assign num = NUM_W'(esel) * NUM_W'(510) + NUM_W'(r_b.wsum) * NUM_W'(16384);
    assign trial = {1'b0, r_rem} - ((NUM_W+1)'(den) << r_bit);
    assign plo = (26'd32768 - 26'(r_b.peak)) * 26'd255 + 26'd32768;
    assign phi = (26'd32768 + 26'(r_b.peak)) * 26'd255 + 26'd32768;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_b <= i_data;
                        r_band <= 2'd0;
                        r_bit <= 4'(Q_BITS - 1);
                        r_state <= S_DIV;
                        r_rem <= '1;
                    end
                end
                S_DIV: begin
                    if (r_bit == 4'(Q_BITS - 1) && r_rem == '1) begin
                        r_rem <= num;
                        r_q <= '0;
                    end else begin
                        logic [Q_BITS-1:0] q;
                        q = r_q;
                        if (!trial[NUM_W]) q[r_bit] = 1'b1;
                        r_q <= q;
                        if (r_bit == '0) begin
                            r_lvl[r_band] <= (r_b.wsum == '0) ? 8'd0 :
                                             (q > 9'd255 ? 8'd255 : q[7:0]);
                            r_bit <= 4'(Q_BITS - 1);
                            r_rem <= '1;
                            if (r_band == 2'd2) begin
                                r_state <= S_OUT;
                                r_bkt_no <= r_b.bucket;
                                r_plo <= plo[23:16];
                                r_phi <= phi[23:16];
                                r_final <= r_b.last;
                            end else begin
                                r_band <= r_band + 2'd1;
                            end
                        end else begin
                            if (!trial[NUM_W]) r_rem <= trial[NUM_W-1:0];
                            r_bit <= r_bit - 4'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_result.bucket_number = r_bkt_no;
        o_result.peak_low_byte = r_plo;
        o_result.peak_high_byte = r_phi;
        o_result.bass_level = i_bands_enabled ? r_lvl[0] : 8'd0;
        o_result.mid_level = i_bands_enabled ? r_lvl[1] : 8'd0;
        o_result.treble_level = i_bands_enabled ? r_lvl[2] : 8'd0;
        o_result.final_bucket = r_final;
    end
endmodule

@@ design/waveform_bucket_reducer.sv @@
// a sample that closes a bucket is registered in the front and queued, and its result
// shows once the back has divided all 3 bands; the front takes one sample per cycle while
// its output slot is free or draining, and the back takes one bucket at a time
// the two-entry queue absorbs results; the front stalls on short buckets or a held output
// reset: synchronous active low, restarts the track, sample_count 256, bands on
// ----------------------------------------------------------------------------
// waveform_bucket_reducer
// min/max peak and weighted band energy overview per bucket
// ----------------------------------------------------------------------------
module waveform_bucket_reducer import wbr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    wbr_stream_if.sink          s_in,
    wbr_stream_if.source        m_out
);
    logic [CFG_BITS-1:0] r_count, count_sel;
    logic r_bands, restart;
    logic fq_v, fq_r, qb_v, qb_r;
    t_bucket fq_d, qb_d;
    t_result res;

    assign restart = i_cfg_we && i_cfg_index == {1'b0, CFG_SAMPLE_COUNT};
    // the front sees the reset length even on the first reset cycle
    assign count_sel = !i_rst_n ? CFG_BITS'(256) : (restart ? i_cfg_data : r_count);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CFG_BITS'(256);
            r_bands <= 1'b1;
        end else if (i_cfg_we && i_cfg_index == {1'b0, CFG_SAMPLE_COUNT}) begin
            r_count <= i_cfg_data;
        end else if (i_cfg_we && i_cfg_index == {1'b0, CFG_BANDS_ENABLED}) begin
            r_bands <= i_cfg_data[0];
        end
    end

    wbr_front u_front (.i_clk, .i_rst_n, .i_cfg_restart(restart),
        .i_count(count_sel),
        .i_valid(s_in.valid), .o_ready(s_in.ready), .i_item(s_in.data),
        .o_valid(fq_v), .i_ready(fq_r), .o_bucket(fq_d));
    wbr_queue u_queue (.i_clk, .i_rst_n, .i_valid(fq_v), .o_ready(fq_r), .i_data(fq_d),
        .o_valid(qb_v), .i_ready(qb_r), .o_data(qb_d));
    wbr_back u_back (.i_clk, .i_rst_n, .i_bands_enabled(r_bands),
        .i_valid(qb_v), .o_ready(qb_r), .i_data(qb_d),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_result(res));
    assign m_out.data = res;
endmodule

@@ design/wbr_checker.sv @@
// ----------------------------------------------------------------------------
// wbr_checker
// port-level checks on the bucket result stream
// ----------------------------------------------------------------------------
`include "waveform_bucket_reducer_assert.svh"
module wbr_checker import wbr_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_result i_out_data
);
    localparam logic [7:0] LAST_BUCKET = 8'(BUCKETS - 1);

    logic       stalled;
    logic       last_seen;
    logic [7:0] byte_sum;

    assign stalled = i_out_valid && !i_out_ready;
    assign last_seen = i_out_valid && i_out_data.final_bucket;
    // bytes mirror around 127.5, both round up only for a zero peak
    assign byte_sum = i_out_data.peak_low_byte + i_out_data.peak_high_byte;

    `WBR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, stalled, i_out_valid && $stable(i_out_data))
    `WBR_ASSERT_IMPL(a_bytes, i_clk, i_rst_n, i_out_valid, byte_sum == 8'd255 || byte_sum == 8'd0)
    `WBR_ASSERT_IMPL(a_final, i_clk, i_rst_n, last_seen, i_out_data.bucket_number == LAST_BUCKET)
endmodule

bind waveform_bucket_reducer wbr_checker u_checker (.i_clk, .i_rst_n,
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready), .i_out_data(m_out.data));
